// ----- rtl/tlik_pkg.sv -----
// package for the two-link inverse kinematics block
// holds widths, status codes, cordic angle table; no dependencies
`default_nettype none
package tlik_pkg;
    localparam int COORD_W = 18;
    localparam int ANGLE_W = 16;
    localparam int LEN_W = 16;
    localparam int STATUS_W = 2;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 12;
    localparam int ATAN_LEN = 24;
    localparam int CFG_IDX_W = 1;
    localparam logic [LEN_W-1:0] LEN_RESET = 16'd1024;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef enum logic [STATUS_W-1:0] {
        ST_SOLVED = 2'd0,
        ST_STRETCHED = 2'd1,
        ST_HELD = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b1;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0: r = 32'h3243F6A8;
            1: r = 32'h1DAC6705;
            2: r = 32'h0FADBAFC;
            3: r = 32'h07F56EA6;
            4: r = 32'h03FEAB76;
            5: r = 32'h01FFD55B;
            6: r = 32'h00FFFAAA;
            7: r = 32'h007FFF55;
            8: r = 32'h003FFFEA;
            9: r = 32'h001FFFFD;
            10: r = 32'h000FFFFF;
            11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;
            13: r = 32'h0001FFFF;
            14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;
            16: r = 32'h00003FFF;
            17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;
            19: r = 32'h000007FF;
            20: r = 32'h000003FF;
            21: r = 32'h000001FF;
            22: r = 32'h000000FF;
            23: r = 32'h0000007F;
            default: r = 32'h0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/tlik_if.sv -----
// valid/ready channel interfaces for the inverse kinematics block
// depends on tlik_pkg
`default_nettype none
interface tlik_in_if;
    import tlik_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [ANGLE_W-1:0] hold_angle0;
    logic signed [ANGLE_W-1:0] hold_angle1;
    modport source (output valid, target_x, target_y, hold_angle0, hold_angle1, input ready);
    modport sink (input valid, target_x, target_y, hold_angle0, hold_angle1, output ready);
endinterface

interface tlik_out_if;
    import tlik_pkg::*;
    logic valid;
    logic ready;
    logic signed [ANGLE_W-1:0] shoulder_angle;
    logic signed [ANGLE_W-1:0] elbow_angle;
    logic [STATUS_W-1:0] solve_status;
    logic singularity_bumped;
    modport source (output valid, shoulder_angle, elbow_angle, solve_status,
                    singularity_bumped, input ready);
    modport sink (input valid, shoulder_angle, elbow_angle, solve_status,
                  singularity_bumped, output ready);
endinterface

interface tlik_cfg_if;
    import tlik_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LEN_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/tlik_cordic.sv -----
// pipelined vectoring cordic atan2, one rotation per stage
// depends on tlik_pkg; input already normalized to [2^29, 2^30)
`default_nettype none
module tlik_cordic #(
    parameter int CORDIC_STAGES = tlik_pkg::DEF_CORDIC_STAGES
) (
    input wire logic clk,
    input wire logic en,
    input wire logic signed [31:0] x_in,
    input wire logic signed [31:0] y_in,
    input wire logic zero_in,
    output logic signed [33:0] z_out
);
    import tlik_pkg::*;
    logic signed [32:0] x_reg [CORDIC_STAGES+1];
    logic signed [32:0] y_reg [CORDIC_STAGES+1];
    logic signed [33:0] z_reg [CORDIC_STAGES+1];
    logic zero_reg [CORDIC_STAGES+1];

    // quarter turn for left half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= zero_in;
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0] <= 33'(y_in);
                    y_reg[0] <= -33'(x_in);
                    z_reg[0] <= HALF_PI_Q30;
                end
                else
                begin
                    x_reg[0] <= -33'(y_in);
                    y_reg[0] <= 33'(x_in);
                    z_reg[0] <= -HALF_PI_Q30;
                end
            end
            else
            begin
                x_reg[0] <= 33'(x_in);
                y_reg[0] <= 33'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({2'b00, atan_q30(i)});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({2'b00, atan_q30(i)});
                end
            end
        end
    end

    assign z_out = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];
endmodule
`default_nettype wire

// ----- rtl/two_link_inverse_kinematics.sv -----
// top level of the two-link inverse kinematics pipeline
// depends on tlik_pkg, tlik_if and tlik_cordic
//
// channel  | dir | handshake   | payload
// in_ch    | in  | valid/ready | target_x, target_y, hold_angle0, hold_angle1
// out_ch   | out | valid/ready | shoulder_angle, elbow_angle, solve_status, flag
// cfg_ch   | in  | valid/ready | index, data
//
// one item per cycle unless the output stalls; the pipe is the eight
// front stages, the 31-step square root pipeline, the normalize stage,
// the three cordic pipelines running side by side and the subtract stage
// the whole pipe advances when the output register is empty or taken
// reset clears valid bits and sets both link lengths to 1.0
`default_nettype none
module two_link_inverse_kinematics #(
    parameter int CORDIC_STAGES = tlik_pkg::DEF_CORDIC_STAGES,
    parameter int ANGLE_FRAC_BITS = tlik_pkg::DEF_ANGLE_FRAC_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    tlik_in_if.sink in_ch,
    tlik_out_if.source out_ch,
    tlik_cfg_if.sink cfg_ch
);
    import tlik_pkg::*;

    localparam int SQ_STEPS = 31;
    localparam int PRE = 8;
    localparam int DEPTH = PRE + SQ_STEPS + 1 + 1 + CORDIC_STAGES + 1 + 1;
    localparam int BUMP = ((1 << ANGLE_FRAC_BITS) + 50) / 100;
    localparam int RSH = 30 - ANGLE_FRAC_BITS;

    logic [LEN_W-1:0] l0_reg, l1_reg;
    logic adv;
    logic [DEPTH-1:0] vld_reg;
    logic out_vld_reg;

    assign adv = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l0_reg <= LEN_RESET;
            l1_reg <= LEN_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_UPPER: l0_reg <= cfg_ch.data;
                REG_LOWER: l1_reg <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    // item sideband carried the whole length
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [ANGLE_W-1:0] h0;
        logic signed [ANGLE_W-1:0] h1;
        logic stretch;
        logic bad;
    } side_t;
    side_t side_reg [DEPTH];

    // stage 0: capture, stretch and zero-length flags
    logic [LEN_W-1:0] p0_l0_reg, p0_l1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].x <= in_ch.target_x;
            side_reg[0].y <= in_ch.target_y;
            side_reg[0].h0 <= in_ch.hold_angle0;
            side_reg[0].h1 <= in_ch.hold_angle1;
            side_reg[0].stretch <= (38'(in_ch.target_x) == 38'(l0_reg) + 38'(l1_reg))
                && (in_ch.target_y == '0);
            side_reg[0].bad <= (l0_reg == '0) || (l1_reg == '0);
            p0_l0_reg <= l0_reg;
            p0_l1_reg <= l1_reg;
        end
    end
    for (genvar k = 1; k < DEPTH; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // stage 1: products
    logic [35:0] xx_reg, yy_reg;
    logic [31:0] aa_reg, bb_reg, ab_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg <= 36'($signed(side_reg[0].x)) * 36'($signed(side_reg[0].x));
            yy_reg <= 36'($signed(side_reg[0].y)) * 36'($signed(side_reg[0].y));
            aa_reg <= 32'(p0_l0_reg) * 32'(p0_l0_reg);
            bb_reg <= 32'(p0_l1_reg) * 32'(p0_l1_reg);
            ab_reg <= 32'(p0_l0_reg) * 32'(p0_l1_reg);
        end
    end

    // stage 2: n, d, m
    logic signed [38:0] n_reg, d_reg, m_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg <= 39'(xx_reg) + 39'(yy_reg) - 39'(aa_reg) - 39'(bb_reg);
            m_reg <= 39'(xx_reg) + 39'(yy_reg) + 39'(aa_reg) - 39'(bb_reg);
            d_reg <= {6'd0, ab_reg, 1'b0};
        end
    end

    // stage 3: reach test, magnitudes
    logic [37:0] na_reg, ma_reg, da_reg;
    logic nneg_reg, mneg_reg, unr_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na_reg <= n_reg[38] ? 38'(-n_reg) : 38'(n_reg);
            ma_reg <= m_reg[38] ? 38'(-m_reg) : 38'(m_reg);
            da_reg <= 38'(d_reg);
            nneg_reg <= n_reg[38];
            mneg_reg <= m_reg[38];
            unr_reg <= (n_reg > d_reg) || (n_reg < -d_reg);
        end
    end

    // stage 4: common shift
    logic [3:0] s_reg;
    logic [3:0] s_next;
    logic [37:0] na4_reg, ma4_reg, da4_reg;
    logic nneg4_reg, mneg4_reg, unr4_reg;
    always_comb
    begin
        logic [37:0] big;
        big = da_reg | na_reg | ma_reg;
        s_next = '0;
        for (int b = 30; b < 38; b++)
            if (big[b])
                s_next = 4'(b - 29);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg <= s_next;
            na4_reg <= na_reg;
            ma4_reg <= ma_reg;
            da4_reg <= da_reg;
            nneg4_reg <= nneg_reg;
            mneg4_reg <= mneg_reg;
            unr4_reg <= unr_reg;
        end
    end

    // stage 5: cut
    logic [29:0] nc_reg, mc_reg, dc_reg;
    logic nneg5_reg, mneg5_reg, unr5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nc_reg <= 30'(na4_reg >> s_reg);
            mc_reg <= 30'(ma4_reg >> s_reg);
            dc_reg <= 30'(da4_reg >> s_reg);
            nneg5_reg <= nneg4_reg;
            mneg5_reg <= mneg4_reg;
            unr5_reg <= unr4_reg;
        end
    end

    // stage 6: d^2 - n^2 as (d-n)(d+n)
    logic [30:0] dmn_reg, dpn_reg;
    logic [29:0] nc6_reg, mc6_reg;
    logic nneg6_reg, mneg6_reg, unr6_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmn_reg <= 31'(dc_reg) - 31'(nc_reg);
            dpn_reg <= 31'(dc_reg) + 31'(nc_reg);
            nc6_reg <= nc_reg;
            mc6_reg <= mc_reg;
            nneg6_reg <= nneg5_reg;
            mneg6_reg <= mneg5_reg;
            unr6_reg <= unr5_reg;
        end
    end

    // stage 7: product, split over 31x16 and 31x15 halves summed
    logic [61:0] rad;
    logic [46:0] plo_reg, phi_reg;
    logic [29:0] nc7_reg, mc7_reg;
    logic nneg7_reg, mneg7_reg, unr7_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg <= 47'(dmn_reg) * 47'(dpn_reg[15:0]);
            phi_reg <= 47'(dmn_reg) * 47'(dpn_reg[30:16]);
            nc7_reg <= nc6_reg;
            mc7_reg <= mc6_reg;
            nneg7_reg <= nneg6_reg;
            mneg7_reg <= mneg6_reg;
            unr7_reg <= unr6_reg;
        end
    end

    // square root pipeline, one result bit per stage
    logic [61:0] sq_rem_reg [SQ_STEPS+1];
    logic [30:0] sq_res_reg [SQ_STEPS+1];
    logic [29:0] sq_n_reg [SQ_STEPS+1];
    logic [29:0] sq_m_reg [SQ_STEPS+1];
    logic sq_nneg_reg [SQ_STEPS+1];
    logic sq_mneg_reg [SQ_STEPS+1];
    logic sq_unr_reg [SQ_STEPS+1];
    assign rad = 62'(plo_reg) + {phi_reg[45:0], 16'd0};
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0] <= rad;
            sq_res_reg[0] <= '0;
            sq_n_reg[0] <= nc7_reg;
            sq_m_reg[0] <= mc7_reg;
            sq_nneg_reg[0] <= nneg7_reg;
            sq_mneg_reg[0] <= mneg7_reg;
            sq_unr_reg[0] <= unr7_reg;
        end
    end
    for (genvar q = 0; q < SQ_STEPS; q++)
    begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - q;
        logic [62:0] trial;
        assign trial = ({sq_res_reg[q], 32'd0} >> (31 - B))
            | (63'd1 << (2 * B));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (63'(sq_rem_reg[q]) >= trial)
                begin
                    sq_rem_reg[q+1] <= 62'(63'(sq_rem_reg[q]) - trial);
                    sq_res_reg[q+1] <= sq_res_reg[q] | (31'd1 << B);
                end
                else
                begin
                    sq_rem_reg[q+1] <= sq_rem_reg[q];
                    sq_res_reg[q+1] <= sq_res_reg[q];
                end
                sq_n_reg[q+1] <= sq_n_reg[q];
                sq_m_reg[q+1] <= sq_m_reg[q];
                sq_nneg_reg[q+1] <= sq_nneg_reg[q];
                sq_mneg_reg[q+1] <= sq_mneg_reg[q];
                sq_unr_reg[q+1] <= sq_unr_reg[q];
            end
        end
    end

    // normalize stage: three vectors into [2^29, 2^30)
    logic [30:0] sv;
    logic signed [31:0] nx, my, sy;
    assign sv = sq_res_reg[SQ_STEPS];
    assign nx = sq_nneg_reg[SQ_STEPS] ? -32'(sq_n_reg[SQ_STEPS]) : 32'(sq_n_reg[SQ_STEPS]);
    assign my = sq_mneg_reg[SQ_STEPS] ? -32'(sq_m_reg[SQ_STEPS]) : 32'(sq_m_reg[SQ_STEPS]);
    assign sy = 32'(sv);

    function automatic logic [4:0] lead(input logic [30:0] v);
        logic [4:0] r;
        r = '0;
        for (int b = 0; b < 31; b++)
            if (v[b])
                r = 5'(b);
        return r;
    endfunction

    logic signed [31:0] ax_reg, ay_reg, ex_reg, ey_reg, bx_reg, by_reg;
    logic az_reg, ez_reg, bz_reg;
    logic unr_n_reg;
    always_ff @(posedge clk)
    begin
        logic [30:0] mt, me, mb;
        logic [30:0] tx, ty;
        logic [4:0] pt, pe, pb;
        if (adv)
        begin
            tx = side_reg[PRE+SQ_STEPS].x[17] ? -31'(side_reg[PRE+SQ_STEPS].x)
                : 31'(side_reg[PRE+SQ_STEPS].x);
            ty = side_reg[PRE+SQ_STEPS].y[17] ? -31'(side_reg[PRE+SQ_STEPS].y)
                : 31'(side_reg[PRE+SQ_STEPS].y);
            mt = tx | ty;
            me = 31'(sq_n_reg[SQ_STEPS]) | sv;
            mb = 31'(sq_m_reg[SQ_STEPS]) | sv;
            pt = lead(mt);
            pe = lead(me);
            pb = lead(mb);
            ax_reg <= 32'(side_reg[PRE+SQ_STEPS].x) <<< (29 - pt);
            ay_reg <= 32'(side_reg[PRE+SQ_STEPS].y) <<< (29 - pt);
            az_reg <= (mt == '0);
            ex_reg <= nx <<< (29 - pe);
            ey_reg <= sy <<< (29 - pe);
            ez_reg <= (me == '0);
            bx_reg <= my <<< (29 - pb);
            by_reg <= sy <<< (29 - pb);
            bz_reg <= (mb == '0);
            unr_n_reg <= sq_unr_reg[SQ_STEPS];
        end
    end

    logic signed [33:0] za, ze, zb;
    tlik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cord_t (
        .clk(clk), .en(adv), .x_in(ax_reg), .y_in(ay_reg), .zero_in(az_reg), .z_out(za));
    tlik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cord_e (
        .clk(clk), .en(adv), .x_in(ex_reg), .y_in(ey_reg), .zero_in(ez_reg), .z_out(ze));
    tlik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cord_b (
        .clk(clk), .en(adv), .x_in(bx_reg), .y_in(by_reg), .zero_in(bz_reg), .z_out(zb));

    logic unr_c_reg [CORDIC_STAGES+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unr_c_reg[0] <= unr_n_reg;
            for (int c = 0; c < CORDIC_STAGES; c++)
                unr_c_reg[c+1] <= unr_c_reg[c];
        end
    end

    // subtract stage
    logic signed [34:0] zs_reg, ze_reg;
    logic unr_s_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zs_reg <= 35'(za) - 35'(zb);
            ze_reg <= 35'(ze);
            unr_s_reg <= unr_c_reg[CORDIC_STAGES];
        end
    end

    function automatic logic signed [ANGLE_W-1:0] to_ang(input logic signed [34:0] z);
        logic signed [34:0] r;
        r = (z + (35'sd1 <<< (RSH - 1))) >>> RSH;
        if (r > 35'sd32767)
            return 16'sh7FFF;
        if (r < -35'sd32768)
            return 16'sh8000;
        return 16'(r);
    endfunction

    // final select into output register
    logic signed [ANGLE_W-1:0] a0_reg, a1_reg;
    logic [STATUS_W-1:0] st_reg;
    logic bump_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld_reg[DEPTH-1];
    end
    always_ff @(posedge clk)
    begin
        logic signed [ANGLE_W-1:0] a0, a1;
        logic [STATUS_W-1:0] st;
        if (adv)
        begin
            if (side_reg[DEPTH-1].stretch)
            begin
                a0 = '0;
                a1 = '0;
                st = ST_STRETCHED;
            end
            else if (side_reg[DEPTH-1].bad || unr_s_reg)
            begin
                a0 = side_reg[DEPTH-1].h0;
                a1 = side_reg[DEPTH-1].h1;
                st = ST_HELD;
            end
            else
            begin
                a0 = to_ang(zs_reg);
                a1 = to_ang(ze_reg);
                st = ST_SOLVED;
            end
            bump_reg <= (a1 == '0);
            a1_reg <= (a1 == '0) ? ANGLE_W'(BUMP) : a1;
            a0_reg <= a0;
            st_reg <= st;
        end
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.shoulder_angle = a0_reg;
    assign out_ch.elbow_angle = a1_reg;
    assign out_ch.solve_status = st_reg;
    assign out_ch.singularity_bumped = bump_reg;
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for the two-link inverse kinematics block
// predicts each result with its own cordic/sqrt model and checks every field
// depends on tlik_pkg, tlik_if and two_link_inverse_kinematics
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import tlik_pkg::*;

    localparam int STAGES = DEF_CORDIC_STAGES;
    localparam int FRAC = DEF_ANGLE_FRAC_BITS;
    localparam int LATENCY = 43 + STAGES;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam longint NORM = 64'sd1 << 30;
    localparam longint BUMP = ((64'sd1 << FRAC) + 50) / 100;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] shoulder;
        logic signed [ANGLE_W-1:0] elbow;
        status_t status;
        logic bumped;
    } solution_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    tlik_in_if in_ch();
    tlik_out_if out_ch();
    tlik_cfg_if cfg_ch();

    two_link_inverse_kinematics dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_ch(cfg_ch.sink)
    );

    logic [LEN_W-1:0] upper_len = LEN_RESET;
    logic [LEN_W-1:0] lower_len = LEN_RESET;
    solution_t expected_solutions[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    int hold_requests = 0;
    int hold_served = 0;
    bit random_stall = 1'b1;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint trunc_shift(longint v, int s);
        longint m;
        m = magnitude(v) >> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint m, z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        m = magnitude(x) > magnitude(y) ? magnitude(x) : magnitude(y);
        while (m >= NORM)
        begin
            x = floor_shift(x, 1);
            y = floor_shift(y, 1);
            m = m >> 1;
        end
        while (m < NORM / 2)
        begin
            x = x * 2;
            y = y * 2;
            m = m << 1;
        end
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = HALF_PI_Q30;
            end
            else
            begin
                t = x; x = -y; y = t; z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(atan_q30(i));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(atan_q30(i));
            end
        end
        return z;
    endfunction

    function automatic longint round_angle(longint z);
        longint r;
        r = floor_shift(z + (64'sd1 << (29 - FRAC)), 30 - FRAC);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic solution_t solve_arm(logic signed [COORD_W-1:0] tx,
                                            logic signed [COORD_W-1:0] ty,
                                            logic signed [ANGLE_W-1:0] h0,
                                            logic signed [ANGLE_W-1:0] h1);
        solution_t s;
        longint x, y, l0, l1, a0, a1, r2, d, n, mm, big, nn, dn, mn, sv;
        int sh;
        x = tx; y = ty; l0 = upper_len; l1 = lower_len;
        if (x == l0 + l1 && y == 0)
        begin
            a0 = 0; a1 = 0; s.status = ST_STRETCHED;
        end
        else
        begin
            r2 = x * x + y * y;
            d = 2 * l0 * l1;
            n = r2 - l0 * l0 - l1 * l1;
            if (l0 == 0 || l1 == 0 || n > d || n < -d)
            begin
                a0 = h0; a1 = h1; s.status = ST_HELD;
            end
            else
            begin
                mm = r2 + l0 * l0 - l1 * l1;
                big = d;
                if (magnitude(n) > big)
                    big = magnitude(n);
                if (magnitude(mm) > big)
                    big = magnitude(mm);
                sh = 0;
                while ((big >> sh) >= NORM)
                    sh++;
                nn = trunc_shift(n, sh);
                dn = trunc_shift(d, sh);
                mn = trunc_shift(mm, sh);
                sv = int_sqrt(dn * dn - nn * nn);
                a1 = round_angle(vector_angle(sv, nn));
                a0 = round_angle(vector_angle(y, x) - vector_angle(sv, mn));
                s.status = ST_SOLVED;
            end
        end
        s.bumped = 1'b0;
        if (a1 == 0)
        begin
            a1 = BUMP;
            s.bumped = 1'b1;
        end
        s.shoulder = a0[ANGLE_W-1:0];
        s.elbow = a1[ANGLE_W-1:0];
        return s;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_solutions.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    solution_t e;
                    e = expected_solutions.pop_front();
                    if (out_ch.shoulder_angle !== e.shoulder)
                        report_mismatch("shoulder_angle", out_ch.shoulder_angle, e.shoulder);
                    if (out_ch.elbow_angle !== e.elbow)
                        report_mismatch("elbow_angle", out_ch.elbow_angle, e.elbow);
                    if (out_ch.solve_status !== e.status)
                        report_mismatch("solve_status", out_ch.solve_status, e.status);
                    if (out_ch.singularity_bumped !== e.bumped)
                        report_mismatch("singularity_bumped", out_ch.singularity_bumped,
                                        e.bumped);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver side ready, long hold counted here
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (hold_served != hold_requests)
        begin
            out_ch.ready <= 1'b0;
            hold_served <= hold_requests;
            hold_off <= HOLD_CYCLES - 1;
        end
        else if (random_stall)
            out_ch.ready <= ($urandom_range(0, 99) < 70);
        else
            out_ch.ready <= 1'b1;
    end

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!random_stall || r < 60)
            return;
        in_ch.valid <= 1'b0;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40))
            @(negedge clk);
    endtask

    task automatic send_target(logic signed [COORD_W-1:0] tx,
                               logic signed [COORD_W-1:0] ty,
                               logic signed [ANGLE_W-1:0] h0,
                               logic signed [ANGLE_W-1:0] h1);
        in_ch.valid <= 1'b1;
        in_ch.target_x <= tx;
        in_ch.target_y <= ty;
        in_ch.hold_angle0 <= h0;
        in_ch.hold_angle1 <= h1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_solutions.push_back(solve_arm(tx, ty, h0, h1));
        @(negedge clk);
        random_gap();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_solutions.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5)
            @(negedge clk);
    endtask

    task automatic write_length(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_UPPER)
            upper_len = val;
        else
            lower_len = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [ANGLE_W-1:0] random_hold();
        return ANGLE_W'(int'($urandom_range(0, 51472)) - 25736);
    endfunction

    task automatic send_reachable();
        longint r, l0, l1, lo, hi;
        real ang;
        l0 = upper_len; l1 = lower_len;
        lo = l0 > l1 ? l0 - l1 : l1 - l0;
        hi = l0 + l1;
        if (hi > 131071)
            hi = 131071;
        r = lo + longint'($urandom_range(0, 10000)) * (hi - lo) / 10000;
        ang = real'(int'($urandom_range(0, 62831)) - 31415) / 10000.0;
        send_target(COORD_W'(longint'(r * $cos(ang))), COORD_W'(longint'(r * $sin(ang))),
                    random_hold(), random_hold());
    endtask

    task automatic send_noise();
        send_target(COORD_W'($urandom), COORD_W'($urandom),
                    ANGLE_W'($urandom), ANGLE_W'($urandom));
    endtask

    task automatic test_directed();
        send_target(2048, 0, 100, -100);
        send_target(2048, 0, 0, 0);
        send_target(0, 0, 25736, 0);
        send_target(0, 0, -25736, 5);
        send_target(-18'sd131072, -18'sd131072, 25736, -25736);
        send_target(18'sd131071, 18'sd131071, -25736, 0);
        send_target(-18'sd131072, 0, 1, 2);
        send_target(0, 18'sd131071, 3, 4);
        send_target(1024, 1024, 0, 0);
        send_target(-1024, 1024, 0, 0);
        send_target(-1024, -1024, 0, 0);
        send_target(1024, -1024, 0, 0);
        send_target(-2048, 0, 7, 7);
        send_target(2047, 0, 0, 0);
        send_target(2047, 1, 0, 0);
        send_target(1448, 0, 0, 0);
        send_target(-1, -1, 0, 0);
    endtask

    task automatic test_extreme_lengths();
        write_length(REG_UPPER, 0);
        send_target(1024, 0, 11, 0);
        send_target(500, 0, 11, 12);
        write_length(REG_UPPER, 16'hFFFF);
        write_length(REG_LOWER, 16'hFFFF);
        send_target(0, 0, 5, 6);
        send_target(18'sd131070, 0, 5, 6);
        send_target(18'sd131071, 0, 5, 6);
        repeat (20)
            send_reachable();
        write_length(REG_LOWER, 0);
        send_target(16'hFFFF, 0, 1, 1);
        send_target(100, 0, 1, 1);
        write_length(REG_UPPER, 1);
        write_length(REG_LOWER, 1);
        send_target(2, 0, 9, 9);
        send_target(1, 1, 9, 9);
        send_target(0, 0, 9, 9);
        repeat (10)
            send_reachable();
    endtask

    task automatic test_random(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 80)
                send_reachable();
            else
                send_noise();
        end
    endtask

    task automatic test_backpressure();
        hold_requests++;
        repeat (120)
            send_reachable();
        wait_drained();
    endtask

    task automatic test_random_lengths();
        for (int k = 0; k < 5; k++)
        begin
            write_length(REG_UPPER, LEN_W'($urandom_range(1, 40000)));
            write_length(REG_LOWER, LEN_W'($urandom_range(1, 40000)));
            test_random(60);
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.hold_angle0 = '0;
        in_ch.hold_angle1 = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_UPPER;
        cfg_ch.data = '0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        random_stall = 1'b0;
        test_random(60);
        random_stall = 1'b1;
        test_random(100);
        test_backpressure();
        test_extreme_lengths();
        test_random_lengths();
        write_length(REG_UPPER, LEN_RESET);
        write_length(REG_LOWER, LEN_RESET);
        test_random(40);
        wait_drained();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
